// ----- design/assert_macros.svh -----
// Assertion macros shared by the SD card init engine RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/sdi_pkg.sv -----
// Package for the SD card SPI init engine: phase codes, command codes, types.
// No dependencies.
package sdi_pkg;
  localparam logic [3:0] RESPONSE_TRIES = 4'd10;
  localparam logic [3:0] IDLE_TRIES = 4'd10;
  localparam logic [3:0] DUMMY_BYTES = 4'd10;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0, PH_DUMMY = 3'd1, PH_READY = 3'd2, PH_FRAME = 3'd3,
    PH_RESP = 3'd4, PH_TRAIL = 3'd5, PH_WAIT = 3'd6, PH_DONE = 3'd7
  } phase_t;

  localparam logic [7:0] C_GO_IDLE = 8'h40;
  localparam logic [7:0] C_OP_MMC = 8'h41;
  localparam logic [7:0] C_IF_COND = 8'h48;
  localparam logic [7:0] C_BLKLEN = 8'h50;
  localparam logic [7:0] C_OP_SD = 8'h69;
  localparam logic [7:0] C_APP = 8'h77;
  localparam logic [7:0] C_OCR = 8'h7A;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [1:0] REG_INIT = 2'd0;
  localparam logic [1:0] REG_READY = 2'd1;
  localparam logic [1:0] REG_RETRY = 2'd2;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  byte_step;
    logic [3:0]  attempt_count;
    logic [7:0]  current_command;
    logic [31:0] current_argument;
    logic [7:0]  init_timer;
    logic [7:0]  ready_timer;
    logic [7:0]  wait_timer;
    logic [31:0] ocr_bytes;
    logic [1:0]  found_type;
  } eng_state_t;

  typedef struct packed {
    logic [7:0] init_timeout_ticks;
    logic [7:0] ready_timeout_ticks;
    logic [7:0] retry_wait_ticks;
  } cfg_t;

  typedef struct packed {
    logic       no_idle_failure;
    logic [1:0] card_type;
    logic       done_res;
    logic       chip_select_high;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } result_t;
endpackage

// ----- design/sdi_step.sv -----
// Combinational next-state and result logic for one engine item.
// Depends on sdi_pkg.
module sdi_step import sdi_pkg::*; (
  input  eng_state_t st,
  input  cfg_t       cfg,
  input  logic [1:0] kind,
  input  logic [7:0] rx,
  output eng_state_t st_next,
  output result_t    res
);
  // Whole step in one pass: the model's helpers become local edits of s.
  always_comb begin
    eng_state_t s;
    logic       ov;
    logic [7:0] ob;
    logic       do_result;
    logic [7:0] r;
    logic       start;
    logic [7:0] scmd;
    logic [31:0] sarg;
    logic       fin;
    logic [1:0] ftype;
    logic       fail;
    logic       ok;
    logic       trail;
    logic       done;
    logic [31:0] ocr_n;
    logic [3:0] bs_n;
    s = st; ov = 1'b0; ob = 8'h00; do_result = 1'b0; r = rx;
    start = 1'b0; scmd = 8'h00; sarg = 32'h0; fin = 1'b0; ftype = 2'd0;
    fail = 1'b0; ok = 1'b0; trail = 1'b0; ocr_n = 32'h0; bs_n = 4'd0;
    unique case (kind)
      KIND_START: begin
        s = '0; s.byte_step = 4'd1; s.phase = PH_DUMMY; ov = 1'b1; ob = 8'hFF;
      end
      KIND_BYTE: begin
        unique case (st.phase)
          PH_DUMMY: begin
            if (st.byte_step < DUMMY_BYTES) begin
              s.byte_step = st.byte_step + 4'd1; ov = 1'b1; ob = 8'hFF;
            end else begin
              s.attempt_count = 4'd0; start = 1'b1; scmd = C_GO_IDLE;
            end
          end
          PH_READY: begin
            if (rx == 8'hFF) begin
              s.phase = PH_FRAME; s.byte_step = 4'd1; ov = 1'b1; ob = st.current_command;
            end else if (st.ready_timer == 8'd0) begin
              do_result = 1'b1; r = 8'hFF;
            end else begin
              ov = 1'b1; ob = 8'hFF;
            end
          end
          PH_FRAME: begin
            if (st.byte_step < 4'd6) begin
              ov = 1'b1;
              unique case (st.byte_step)
                4'd1: ob = st.current_argument[31:24];
                4'd2: ob = st.current_argument[23:16];
                4'd3: ob = st.current_argument[15:8];
                4'd4: ob = st.current_argument[7:0];
                default: ob = (st.current_command == C_GO_IDLE) ? 8'h95 :
                              (st.current_command == C_IF_COND) ? 8'h87 : 8'h01;
              endcase
              s.byte_step = st.byte_step + 4'd1;
            end else begin
              s.phase = PH_RESP; s.byte_step = 4'd1; ov = 1'b1; ob = 8'hFF;
            end
          end
          PH_RESP: begin
            if (!rx[7] || st.byte_step >= RESPONSE_TRIES) do_result = 1'b1;
            else begin
              s.byte_step = st.byte_step + 4'd1; ov = 1'b1; ob = 8'hFF;
            end
          end
          PH_TRAIL: begin
            ocr_n = {st.ocr_bytes[23:0], rx};
            bs_n = st.byte_step + 4'd1;
            s.ocr_bytes = ocr_n; s.byte_step = bs_n;
            if (bs_n < 4'd4) begin
              ov = 1'b1; ob = 8'hFF;
            end else if (st.current_command == C_IF_COND) begin
              if (ocr_n[15:8] == 8'h01 && ocr_n[7:0] == 8'hAA) begin
                s.attempt_count = 4'd1; s.found_type = 2'd0; start = 1'b1; scmd = C_APP;
              end else fin = 1'b1;
            end else begin
              fin = 1'b1; ftype = ocr_n[30] ? 2'd3 : 2'd2;
            end
          end
          default: ;
        endcase
      end
      KIND_TICK: begin
        if (st.init_timer != 8'd0) s.init_timer = st.init_timer - 8'd1;
        if (st.ready_timer != 8'd0) s.ready_timer = st.ready_timer - 8'd1;
        if (st.wait_timer != 8'd0) s.wait_timer = st.wait_timer - 8'd1;
        if (st.phase == PH_WAIT && s.wait_timer == 8'd0) begin
          start = 1'b1; scmd = C_GO_IDLE;
        end
      end
      default: ;
    endcase

    // Command reply handling.
    if (do_result) begin
      unique case (st.current_command)
        C_GO_IDLE: begin
          if (st.attempt_count >= IDLE_TRIES) begin
            if (r == 8'd1) begin
              s.init_timer = cfg.init_timeout_ticks; s.attempt_count = 4'd0;
              start = 1'b1; scmd = C_IF_COND; sarg = 32'h1AA;
            end else fin = 1'b1;
          end else if (r == 8'd1) begin
            s.attempt_count = IDLE_TRIES; start = 1'b1; scmd = C_GO_IDLE;
          end else begin
            s.attempt_count = st.attempt_count + 4'd1;
            if (cfg.retry_wait_ticks == 8'd0) begin
              start = 1'b1; scmd = C_GO_IDLE;
            end else begin
              s.wait_timer = cfg.retry_wait_ticks; s.phase = PH_WAIT;
            end
          end
        end
        C_IF_COND: begin
          if (r == 8'd1) trail = 1'b1;
          else begin
            s.found_type = 2'd0; start = 1'b1; scmd = C_APP;
          end
        end
        C_APP: begin
          if (r <= 8'd1) begin
            start = 1'b1; scmd = C_OP_SD;
            sarg = (st.attempt_count == 4'd1) ? 32'h4000_0000 : 32'h0;
          end else fail = 1'b1;
        end
        C_OP_SD: begin
          if (st.attempt_count != 4'd1 && st.found_type == 2'd0) begin
            start = 1'b1;
            if (r <= 8'd1) begin
              s.found_type = 2'd2; scmd = C_APP;
            end else begin
              s.found_type = 2'd1; scmd = C_OP_MMC;
            end
          end else if (r == 8'd0) ok = 1'b1;
          else fail = 1'b1;
        end
        C_OP_MMC: begin
          if (r == 8'd0) ok = 1'b1; else fail = 1'b1;
        end
        C_OCR: begin
          if (r == 8'd0) trail = 1'b1; else fin = 1'b1;
        end
        C_BLKLEN: begin
          fin = 1'b1; ftype = (r == 8'd0) ? st.found_type : 2'd0;
        end
        default: fin = 1'b1;
      endcase
    end

    // Loop outcome: failed or passed initialization attempt.
    if (fail) begin
      if (st.attempt_count != 4'd1 && st.found_type == 2'd0) begin
        s.found_type = 2'd1; start = 1'b1; scmd = C_OP_MMC;
      end else if (st.init_timer == 8'd0) fin = 1'b1;
      else begin
        start = 1'b1; scmd = (st.found_type == 2'd1) ? C_OP_MMC : C_APP;
      end
    end
    if (ok) begin
      if (st.init_timer == 8'd0) fin = 1'b1;
      else if (st.attempt_count == 4'd1) begin
        start = 1'b1; scmd = C_OCR;
      end else begin
        start = 1'b1; scmd = C_BLKLEN; sarg = 32'd512;
      end
    end
    if (trail) begin
      s.phase = PH_TRAIL; s.byte_step = 4'd0; s.ocr_bytes = 32'h0; ov = 1'b1; ob = 8'hFF;
    end
    if (start) begin
      s.current_command = scmd; s.current_argument = sarg;
      s.ready_timer = cfg.ready_timeout_ticks; s.phase = PH_READY; s.byte_step = 4'd0;
      ov = 1'b1; ob = 8'hFF;
    end
    if (fin) begin
      s.found_type = ftype; s.phase = PH_DONE;
    end

    st_next = s;
    done = (s.phase == PH_DONE);
    res.tx_valid = ov;
    res.tx_byte = ob;
    res.chip_select_high = (s.phase == PH_DUMMY || s.phase == PH_IDLE || done);
    res.done_res = done;
    res.card_type = done ? s.found_type : 2'd0;
    res.no_idle_failure = done && s.found_type == 2'd0 && s.current_command == C_GO_IDLE;
  end
endmodule

// ----- design/sd_spi_card_init_engine_unit.sv -----
// Top level of the SD card SPI-mode init engine: input register, state, output skid.
// Depends on sdi_pkg, sdi_step and assert_macros.svh.
//
// Each request (start, received byte or timer tick) yields one result carrying the
// next SPI byte and the card status. Items are accepted every cycle while the output
// queue has room; a request is held in the input register, passes once through the
// step logic, and its result is written into the output queue. The state register sits
// behind that single pass, so back-to-back requests chain without gaps. A two-entry
// output queue keeps the input side open while a result waits; the input stalls only
// when the queue would overflow because the receiver holds off.
`include "assert_macros.svh"
module sd_spi_card_init_engine_unit import sdi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // tx_valid, tx_byte[8:1], chip_select_high, done_res,
                                 // card_type[12:11], no_idle_failure, zeros[15:14]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  cfg_t       cfg;
  eng_state_t st, st_next;
  result_t    res;
  logic       in_v;
  logic [1:0] in_kind;
  logic [7:0] in_rx;
  result_t    q0, q1;
  logic [1:0] cnt;
  logic       pop;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.init_timeout_ticks <= 8'd100;
      cfg.ready_timeout_ticks <= 8'd50;
      cfg.retry_wait_ticks <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT:  cfg.init_timeout_ticks <= cfg_data;
        REG_READY: cfg.ready_timeout_ticks <= cfg_data;
        REG_RETRY: cfg.retry_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept when the queue holds room for every result in flight after this edge.
  assign s_tready = (cnt + {1'b0, in_v}) <= ({1'b0, pop} + 2'd1);

  always_ff @(posedge clk) begin
    if (rst) in_v <= 1'b0;
    else in_v <= s_tvalid && s_tready;
    in_kind <= s_tuser;
    in_rx <= s_tdata;
  end

  sdi_step u_step (.st(st), .cfg(cfg), .kind(in_kind), .rx(in_rx),
                   .st_next(st_next), .res(res));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_v) begin
      st <= st_next;
    end
  end

  // Output queue, q0 is the head.
  assign pop = m_tvalid && m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, in_v} - {1'b0, pop};
    end
    if (pop) begin
      q0 <= (cnt == 2'd2) ? q1 : res;
      if (cnt == 2'd2 && in_v) q1 <= res;
    end else if (in_v) begin
      if (cnt == 2'd0) q0 <= res;
      else q1 <= res;
    end
  end

  assign m_tvalid = cnt != 2'd0;
  assign m_tdata = {2'b00, q0};

  `ASSERT_CLK(a_cnt_max, clk, rst, cnt <= 2'd2)
  `ASSERT_NEXT(a_no_overflow, clk, rst, cnt == 2'd2 && !pop, !in_v || cnt != 2'd2)
  `ASSERT_NEXT(a_done_cs, clk, rst, in_v && res.done_res, q0.chip_select_high || q1.chip_select_high)
endmodule

// ----- tb/sd_spi_card_init_engine_unit_checker.sv -----
// Checker for the SD card SPI init engine: predicts every reply from the accepted
// requests and compares it with the output stream. Depends on sdi_pkg.
`timescale 1ns / 100ps
module sd_spi_card_init_engine_unit_checker import sdi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // tx_valid, tx_byte[8:1], chip_select_high, done_res,
                                 // card_type[12:11], no_idle_failure, zeros[15:14]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);

  // Shadow configuration and engine state.
  logic [7:0]  init_ticks, ready_ticks, retry_ticks;
  phase_t      ph;
  logic [3:0]  step_cnt, attempts;
  logic [7:0]  cmd;
  logic [31:0] arg, ocr;
  logic [7:0]  init_tmr, ready_tmr, wait_tmr;
  logic [1:0]  ftype;
  logic        tx_v;
  logic [7:0]  tx_b;

  result_t expected_replies[$];

  task automatic emit(input logic [7:0] b);
    tx_v = 1'b1;
    tx_b = b;
  endtask

  task automatic begin_command(input logic [7:0] c, input logic [31:0] a);
    cmd = c;
    arg = a;
    ready_tmr = ready_ticks;
    ph = PH_READY;
    step_cnt = 4'd0;
    emit(8'hFF);
  endtask

  task automatic finish_seq(input logic [1:0] t);
    ftype = t;
    ph = PH_DONE;
  endtask

  task automatic begin_trail();
    ph = PH_TRAIL;
    step_cnt = 4'd0;
    ocr = 32'd0;
    emit(8'hFF);
  endtask

  function automatic logic [7:0] frame_byte(input logic [3:0] k);
    if (k == 0) return cmd;
    if (k <= 4) return 8'(arg >> (8 * (4 - k)));
    if (cmd == C_GO_IDLE) return 8'h95;
    if (cmd == C_IF_COND) return 8'h87;
    return 8'h01;
  endfunction

  // Failed ACMD41/CMD1 attempt; attempts == 1 marks the version 2 path.
  task automatic attempt_failed();
    if (attempts != 1 && ftype == 0) begin
      ftype = 2'd1;
      begin_command(C_OP_MMC, 0);
    end else if (init_tmr == 0) begin
      finish_seq(2'd0);
    end else if (ftype == 1) begin
      begin_command(C_OP_MMC, 0);
    end else begin
      begin_command(C_APP, 0);
    end
  endtask

  task automatic attempt_ok();
    if (init_tmr == 0) finish_seq(2'd0);
    else if (attempts == 1) begin_command(C_OCR, 0);
    else begin_command(C_BLKLEN, 32'd512);
  endtask

  task automatic handle_r1(input logic [7:0] r);
    case (cmd)
      C_GO_IDLE: begin
        if (attempts >= IDLE_TRIES) begin
          if (r == 1) begin
            init_tmr = init_ticks;
            attempts = 4'd0;
            begin_command(C_IF_COND, 32'h1AA);
          end else begin
            finish_seq(2'd0);
          end
        end else if (r == 1) begin
          attempts = IDLE_TRIES;
          begin_command(C_GO_IDLE, 0);
        end else begin
          attempts = attempts + 4'd1;
          if (retry_ticks == 0) begin_command(C_GO_IDLE, 0);
          else begin
            wait_tmr = retry_ticks;
            ph = PH_WAIT;
          end
        end
      end
      C_IF_COND: begin
        if (r == 1) begin_trail();
        else begin
          ftype = 2'd0;
          begin_command(C_APP, 0);
        end
      end
      C_APP: begin
        if (r <= 1) begin_command(C_OP_SD, attempts == 1 ? 32'h4000_0000 : 32'd0);
        else attempt_failed();
      end
      C_OP_SD: begin
        if (attempts != 1 && ftype == 0) begin
          if (r <= 1) begin
            ftype = 2'd2;
            begin_command(C_APP, 0);
          end else begin
            ftype = 2'd1;
            begin_command(C_OP_MMC, 0);
          end
        end else if (r == 0) attempt_ok();
        else attempt_failed();
      end
      C_OP_MMC: begin
        if (r == 0) attempt_ok();
        else attempt_failed();
      end
      C_OCR: begin
        if (r == 0) begin_trail();
        else finish_seq(2'd0);
      end
      C_BLKLEN: finish_seq(r == 0 ? ftype : 2'd0);
      default: finish_seq(2'd0);
    endcase
  endtask

  // Trailing bytes: the CMD8 echo or the OCR word.
  task automatic trail_complete();
    if (cmd == C_IF_COND) begin
      if (ocr[15:8] == 8'h01 && ocr[7:0] == 8'hAA) begin
        attempts = 4'd1;
        ftype = 2'd0;
        begin_command(C_APP, 0);
      end else begin
        finish_seq(2'd0);
      end
    end else begin
      finish_seq(ocr[30] ? 2'd3 : 2'd2);
    end
  endtask

  task automatic take_byte(input logic [7:0] rx);
    case (ph)
      PH_DUMMY: begin
        if (step_cnt < DUMMY_BYTES) begin
          step_cnt = step_cnt + 4'd1;
          emit(8'hFF);
        end else begin
          attempts = 4'd0;
          begin_command(C_GO_IDLE, 0);
        end
      end
      PH_READY: begin
        if (rx == 8'hFF) begin
          ph = PH_FRAME;
          step_cnt = 4'd1;
          emit(frame_byte(4'd0));
        end else if (ready_tmr == 0) begin
          handle_r1(8'hFF);
        end else begin
          emit(8'hFF);
        end
      end
      PH_FRAME: begin
        if (step_cnt < 6) begin
          emit(frame_byte(step_cnt));
          step_cnt = step_cnt + 4'd1;
        end else begin
          ph = PH_RESP;
          step_cnt = 4'd1;
          emit(8'hFF);
        end
      end
      PH_RESP: begin
        if (!rx[7] || step_cnt >= RESPONSE_TRIES) handle_r1(rx);
        else begin
          step_cnt = step_cnt + 4'd1;
          emit(8'hFF);
        end
      end
      PH_TRAIL: begin
        ocr = {ocr[23:0], rx};
        step_cnt = step_cnt + 4'd1;
        if (step_cnt < 4) emit(8'hFF);
        else trail_complete();
      end
      default: ;
    endcase
  endtask

  // Next reply of the engine for one accepted request.
  task automatic engine_next(input logic [1:0] kind, input logic [7:0] rx,
                             output result_t res);
    logic done;
    tx_v = 1'b0;
    tx_b = 8'd0;
    if (kind == KIND_START) begin
      step_cnt = 4'd1;
      attempts = 4'd0;
      cmd = 8'd0;
      arg = 32'd0;
      ocr = 32'd0;
      ftype = 2'd0;
      init_tmr = 8'd0;
      ready_tmr = 8'd0;
      wait_tmr = 8'd0;
      ph = PH_DUMMY;
      emit(8'hFF);
    end else if (kind == KIND_BYTE) begin
      take_byte(rx);
    end else if (kind == KIND_TICK) begin
      if (init_tmr != 0) init_tmr = init_tmr - 8'd1;
      if (ready_tmr != 0) ready_tmr = ready_tmr - 8'd1;
      if (wait_tmr != 0) wait_tmr = wait_tmr - 8'd1;
      if (ph == PH_WAIT && wait_tmr == 0) begin_command(C_GO_IDLE, 0);
    end
    done = (ph == PH_DONE);
    res.tx_valid = tx_v;
    res.tx_byte = tx_b;
    res.chip_select_high = (ph == PH_DUMMY || ph == PH_IDLE || done);
    res.done_res = done;
    res.card_type = done ? ftype : 2'd0;
    res.no_idle_failure = done && ftype == 0 && cmd == C_GO_IDLE;
  endtask

  assign pending = expected_replies.size();

  // Track configuration, predict accepted requests, compare accepted replies.
  always @(posedge clk) begin
    result_t exp_r;
    result_t got;
    if (rst) begin
      init_ticks <= 8'd100;
      ready_ticks <= 8'd50;
      retry_ticks <= 8'd20;
      ph <= PH_IDLE;
      step_cnt <= 4'd0;
      attempts <= 4'd0;
      cmd <= 8'd0;
      arg <= 32'd0;
      ocr <= 32'd0;
      init_tmr <= 8'd0;
      ready_tmr <= 8'd0;
      wait_tmr <= 8'd0;
      ftype <= 2'd0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INIT:  init_ticks = cfg_data;
          REG_READY: ready_ticks = cfg_data;
          REG_RETRY: retry_ticks = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        engine_next(s_tuser, s_tdata, exp_r);
        expected_replies.push_back(exp_r);
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[13:0];
        if (expected_replies.size() == 0) begin
          if (fail_count < 10) $display("unexpected reply %h", m_tdata);
          fail_count = fail_count + 1;
        end else begin
          exp_r = expected_replies.pop_front();
          if (got.tx_valid != exp_r.tx_valid || got.tx_byte != exp_r.tx_byte ||
              got.chip_select_high != exp_r.chip_select_high ||
              got.done_res != exp_r.done_res || got.card_type != exp_r.card_type ||
              got.no_idle_failure != exp_r.no_idle_failure || m_tdata[15:14] != 2'b00) begin
            if (fail_count < 10)
              $display("reply mismatch: exp v=%b b=%h cs=%b d=%b t=%0d ni=%b, got %h",
                       exp_r.tx_valid, exp_r.tx_byte, exp_r.chip_select_high,
                       exp_r.done_res, exp_r.card_type, exp_r.no_idle_failure, m_tdata);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sd_spi_card_init_engine_unit_test.sv -----
// Test top for the SD card SPI init engine: drives card bring-up sessions and noise,
// varies configuration and flow control. Depends on sdi_pkg and the checker module.
`timescale 1ns / 100ps
module sd_spi_card_init_engine_unit_test import sdi_pkg::*;;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic [1:0]  s_tuser = KIND_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_INIT;
  logic [7:0]  cfg_data = 8'd0;
  int          fail_count;
  int          pending;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          items_sent = 0;
  logic [7:0]  retry_now = 8'd20;

  always #5 clk = ~clk;

  sd_spi_card_init_engine_unit dut (.*);

  sd_spi_card_init_engine_unit_checker checker_i (.*);

  // Receiver side: random stalls, plus a long hold-off when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        m_tready = 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [7:0] rx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = kind;
    s_tdata = rx;
    do @(posedge clk); while (!s_tready);
    items_sent = items_sent + 1;
  endtask

  // Received byte, with an occasional timer tick slipped in ahead of it.
  task automatic card_byte(input logic [7:0] rx);
    if ($urandom_range(9) == 0) send_req(KIND_TICK, 8'($urandom));
    send_req(KIND_BYTE, rx);
  endtask

  // Mostly the intended reply, sometimes a random one.
  function automatic logic [7:0] reply(input logic [7:0] good);
    return ($urandom_range(15) == 0) ? 8'($urandom) : good;
  endfunction

  // One command exchange: busy bytes, ready, frame slots, polls, then R1.
  task automatic card_command(input logic [7:0] r1);
    int n;
    n = $urandom_range(2);
    repeat (n) card_byte(8'($urandom_range(254)));
    card_byte(8'hFF);
    repeat (6) card_byte(8'($urandom));
    n = $urandom_range(2);
    repeat (n) card_byte(8'h80 | 8'($urandom));
    card_byte(r1);
  endtask

  // A full bring-up as a card would answer it, with random deviations.
  task automatic card_session();
    logic [7:0] r;
    send_req(KIND_START, 8'($urandom));
    repeat (10) card_byte(8'($urandom));
    if ($urandom_range(3) == 0) begin
      card_command(8'h05);
      repeat (int'(retry_now) + 1) send_req(KIND_TICK, 8'($urandom));
    end
    card_command(reply(8'h01));
    card_command(reply(8'h01));
    if ($urandom_range(1) == 0) begin
      card_command(reply(8'h01));
      card_byte(8'($urandom));
      card_byte(8'($urandom));
      card_byte(reply(8'h01));
      card_byte(reply(8'hAA));
      card_command(reply(8'($urandom_range(1))));
      card_command(reply(8'h00));
      card_command(reply(8'h00));
      repeat (4) card_byte(8'($urandom));
    end else begin
      card_command(reply(8'h05));
      card_command(reply(8'h01));
      r = ($urandom_range(1) == 0) ? 8'h00 : 8'h05;
      card_command(reply(r));
      if (r == 8'h00) begin
        card_command(reply(8'h00));
        card_command(reply(8'h00));
      end else begin
        card_command(reply(8'h00));
      end
      card_command(reply(8'h00));
    end
    // Some trailing noise after the end of the sequence.
    repeat ($urandom_range(3)) send_req(2'($urandom_range(2)), 8'($urandom));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_RETRY) retry_now = val;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int ph_i;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: stray items while idle, restart, field extremes.
    send_req(KIND_BYTE, 8'h00);
    send_req(KIND_TICK, 8'hFF);
    send_req(KIND_START, 8'h00);
    send_req(KIND_BYTE, 8'hFF);
    send_req(KIND_TICK, 8'h00);
    send_req(KIND_START, 8'hFF);
    repeat (10) send_req(KIND_BYTE, 8'h80);
    send_req(KIND_BYTE, 8'h7F);
    repeat (3) send_req(KIND_TICK, 8'h55);
    send_req(KIND_BYTE, 8'hFF);
    drain();

    for (ph_i = 0; ph_i < 4; ph_i++) begin
      case (ph_i)
        0: begin
          write_reg(REG_INIT, 8'd100);
          write_reg(REG_READY, 8'd50);
          write_reg(REG_RETRY, 8'd20);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(REG_INIT, 8'd1);
          write_reg(REG_READY, 8'd1);
          write_reg(REG_RETRY, 8'd0);
          send_idle_pct = 72;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(REG_INIT, 8'd255);
          write_reg(REG_READY, 8'd255);
          write_reg(REG_RETRY, 8'd255);
          send_idle_pct = 0;
          recv_stall_pct = 72;
        end
        default: begin
          write_reg(REG_INIT, 8'($urandom_range(1, 255)));
          write_reg(REG_READY, 8'($urandom_range(1, 255)));
          write_reg(REG_RETRY, 8'($urandom_range(0, 8)));
          send_idle_pct = 35;
          recv_stall_pct = 35;
        end
      endcase
      if (ph_i == 0) hold_cycles = 300;
      while (items_sent < 25 + 160 * (ph_i + 1)) card_session();
      drain();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
